[rtl/core/assert_macros.svh]
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define TOF_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define TOF_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/core/tdc_tof_pkg.sv]
package tdc_tof_pkg;

  localparam int FINE_W     = 23;
  localparam int NUM_W      = 47;
  localparam int COARSE_W   = 33;
  localparam int RESULT_W   = 48;
  localparam int DIV_STAGES = NUM_W;

  localparam logic [9:0] PERIOD_RESET = 10'd125;
  localparam logic [5:0] SPANS_RESET  = 6'd10;

  typedef enum logic [0:0] {
    REG_CLOCK_PERIOD  = 1'b0,
    REG_CALIB_PERIODS = 1'b1
  } tdc_tof_reg_t;

  typedef struct packed {
    logic              channel;
    logic [FINE_W-1:0] calib_first;
    logic [FINE_W-1:0] calib_second;
    logic [FINE_W-1:0] time_first;
    logic [FINE_W-1:0] time_stop;
    logic [FINE_W-1:0] clock_count;
  } tdc_tof_in_t;

  typedef struct packed {
    logic                       channel_out;
    logic signed [RESULT_W-1:0] flight_time;
    logic                       calib_equal;
    logic                       saturated;
  } tdc_tof_out_t;

  // Item state while it walks through the divider.
  typedef struct packed {
    logic                channel;
    logic                equal;
    logic                neg;
    logic [FINE_W-1:0]   den_mag;
    logic [FINE_W-1:0]   rem;
    logic [NUM_W-1:0]    nq;
    logic [COARSE_W-1:0] coarse;
  } tdc_tof_pipe_t;

endpackage

[rtl/core/tdc_tof_front.sv]
module tdc_tof_front
  import tdc_tof_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_valid,
  input  tdc_tof_in_t   in_beat,
  input  logic [9:0]    period,
  input  logic [5:0]    spans_cfg,
  output logic          out_valid,
  output tdc_tof_pipe_t out_pipe
);

  logic                     a_valid_r;
  logic                     a_channel_r, a_equal_r;
  logic signed [23:0]       a_diff_r, a_den_r;
  logic signed [17:0]       a_pspan_r;
  logic [COARSE_W-1:0]      a_coarse_r;
  logic signed [23:0]       diff_nxt, den_nxt;
  logic signed [6:0]        spans;
  logic signed [17:0]       pspan_nxt;
  logic [15:0]              pabs;
  logic [FINE_W-1:0]        dabs, den_abs;
  logic [38:0]              prod;
  logic [17:0]              pneg;
  logic [23:0]              dneg, denneg;
  logic                     b_valid_r;
  tdc_tof_pipe_t            b_pipe_r;

  always_comb begin
    diff_nxt  = $signed({1'b0, in_beat.time_first}) - $signed({1'b0, in_beat.time_stop});
    den_nxt   = $signed({1'b0, in_beat.calib_second}) - $signed({1'b0, in_beat.calib_first});
    spans     = $signed({1'b0, spans_cfg}) - 7'sd1;
    pspan_nxt = 18'($signed({1'b0, period})) * 18'(spans);
    pneg      = 18'(-a_pspan_r);
    dneg      = 24'(-a_diff_r);
    denneg    = 24'(-a_den_r);
    pabs      = a_pspan_r[17] ? pneg[15:0] : a_pspan_r[15:0];
    dabs      = a_diff_r[23] ? dneg[22:0] : a_diff_r[22:0];
    den_abs   = a_den_r[23] ? denneg[22:0] : a_den_r[22:0];
    prod      = 39'(pabs) * 39'(dabs);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
    end else if (en) begin
      a_valid_r <= in_valid;
      b_valid_r <= a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_channel_r <= in_beat.channel;
      a_equal_r   <= (in_beat.calib_first == in_beat.calib_second);
      a_diff_r    <= diff_nxt;
      a_den_r     <= den_nxt;
      a_pspan_r   <= pspan_nxt;
      a_coarse_r  <= COARSE_W'(period) * COARSE_W'(in_beat.clock_count);
      b_pipe_r.channel <= a_channel_r;
      b_pipe_r.equal   <= a_equal_r;
      b_pipe_r.neg     <= a_pspan_r[17] ^ a_diff_r[23] ^ a_den_r[23];
      b_pipe_r.den_mag <= den_abs;
      b_pipe_r.rem     <= '0;
      b_pipe_r.nq      <= {prod, 8'd0};
      b_pipe_r.coarse  <= a_coarse_r;
    end
  end

  assign out_valid = b_valid_r;
  assign out_pipe  = b_pipe_r;

endmodule

[rtl/core/tdc_tof_div_stage.sv]
module tdc_tof_div_stage
  import tdc_tof_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_valid,
  input  tdc_tof_pipe_t in_pipe,
  output logic          out_valid,
  output tdc_tof_pipe_t out_pipe
);

  logic [FINE_W:0] trial, diff;
  logic            ge;
  logic            valid_r;
  tdc_tof_pipe_t   pipe_r;
  tdc_tof_pipe_t   pipe_nxt;

  // One restoring step: one quotient bit per stage.
  always_comb begin
    trial        = {in_pipe.rem, in_pipe.nq[NUM_W-1]};
    ge           = trial >= {1'b0, in_pipe.den_mag};
    diff         = trial - {1'b0, in_pipe.den_mag};
    pipe_nxt     = in_pipe;
    pipe_nxt.rem = ge ? diff[FINE_W-1:0] : trial[FINE_W-1:0];
    pipe_nxt.nq  = {in_pipe.nq[NUM_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pipe_r <= pipe_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_pipe  = pipe_r;

endmodule

[rtl/core/tdc_tof_finish.sv]
module tdc_tof_finish
  import tdc_tof_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_valid,
  input  tdc_tof_pipe_t in_pipe,
  output logic          out_valid,
  output tdc_tof_out_t  out_beat
);

  logic signed [RESULT_W:0] fine, total;
  logic signed [RESULT_W:0] coarse_ext;
  logic                     sat;
  logic signed [RESULT_W-1:0] clamp;
  logic                     valid_r;
  tdc_tof_out_t             beat_r;

  always_comb begin
    fine = $signed({2'b00, in_pipe.nq});
    if (in_pipe.equal) begin
      fine = '0;
    end else if (in_pipe.neg) begin
      fine = -$signed({2'b00, in_pipe.nq});
    end
    coarse_ext = $signed({8'd0, in_pipe.coarse, 8'd0});
    total      = fine + coarse_ext;
    sat        = total[RESULT_W] != total[RESULT_W-1];
    clamp      = total[RESULT_W] ? {1'b1, {(RESULT_W-1){1'b0}}}
                                 : {1'b0, {(RESULT_W-1){1'b1}}};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      beat_r.channel_out <= in_pipe.channel;
      beat_r.flight_time <= sat ? clamp : total[RESULT_W-1:0];
      beat_r.calib_equal <= in_pipe.equal;
      beat_r.saturated   <= sat;
    end
  end

  assign out_valid = valid_r;
  assign out_beat  = beat_r;

endmodule

[rtl/core/tdc_time_of_flight_calc_top.sv]
// Time-of-flight calculator for one stop reading of a time-to-digital converter.
// Each input beat carries the calibration counts, the fine counts and the coarse
// clock count of one stop; each result beat gives the flight time in 1/256 ns,
// saturated to 48 signed bits, with flags for equal calibration counts and for
// clamping. The block takes one beat per clock while it is not held: two stages
// form the differences and the numerator product, 47 stages each produce one
// quotient bit of a restoring divider, and a final stage applies the sign, adds
// the coarse term and saturates. The whole pipeline advances together; it holds
// only while a result sits in the output register with out_stall high, so in_stall
// follows out_stall in that case. Configuration writes are always taken (cfg_ready
// is tied high) and must occur while idle.
module tdc_time_of_flight_calc_top
  import tdc_tof_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_stall,
  input  tdc_tof_in_t  in_beat,
  output logic         out_valid,
  input  logic         out_stall,
  output tdc_tof_out_t out_beat,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  tdc_tof_reg_t cfg_index,
  input  logic [9:0]   cfg_data
);

`include "assert_macros.svh"

  logic [9:0]    period_r;
  logic [5:0]    spans_r;
  logic          en;
  logic          v [DIV_STAGES+1];
  tdc_tof_pipe_t p [DIV_STAGES+1];

  // Register file for the two settings.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= PERIOD_RESET;
      spans_r  <= SPANS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_CLOCK_PERIOD:  period_r <= cfg_data;
        REG_CALIB_PERIODS: spans_r  <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  assign cfg_ready = 1'b1;

  // Global advance: stop only when the held result is not taken.
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  tdc_tof_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_valid),
    .in_beat   (in_beat),
    .period    (period_r),
    .spans_cfg (spans_r),
    .out_valid (v[0]),
    .out_pipe  (p[0])
  );

  for (genvar i = 0; i < DIV_STAGES; i++) begin : g_div
    tdc_tof_div_stage u_stage (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (en),
      .in_valid  (v[i]),
      .in_pipe   (p[i]),
      .out_valid (v[i+1]),
      .out_pipe  (p[i+1])
    );
  end

  tdc_tof_finish u_finish (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (v[DIV_STAGES]),
    .in_pipe   (p[DIV_STAGES]),
    .out_valid (out_valid),
    .out_beat  (out_beat)
  );

  // The coarse term alone stays below 2^41, so it can never clamp.
  `TOF_ASSERT(a_equal_no_sat, out_valid && out_beat.calib_equal |-> !out_beat.saturated, "equal calibration result clamped")
  // A clamped result sits exactly at one end of the range.
  `TOF_ASSERT(a_sat_at_limit, out_valid && out_beat.saturated |-> (out_beat.flight_time == {1'b0, {(RESULT_W-1){1'b1}}}) || (out_beat.flight_time == {1'b1, {(RESULT_W-1){1'b0}}}), "clamped value not at a limit")
  // Reset flushes the pipeline.
  `TOF_ASSERT_RST(a_reset_flush, !rst_n |=> !out_valid, "result after reset")

endmodule

[verif/tb_top.sv]
`timescale 1ns / 100ps

// Top-level check of the time-of-flight calculator. Stop readings are pushed
// through the input channel while the result channel stalls at random; every
// accepted reading has its flight time computed here and queued, and every
// result beat is compared against the oldest queued flight time.
module tb_top;
  import tdc_tof_pkg::*;

  logic         clk;
  logic         rst_n;
  logic         in_valid;
  logic         in_stall;
  tdc_tof_in_t  in_beat;
  logic         out_valid;
  logic         out_stall;
  tdc_tof_out_t out_beat;
  logic         cfg_valid;
  logic         cfg_ready;
  tdc_tof_reg_t cfg_index;
  logic [9:0]   cfg_data;

  // Local copies of the two configuration registers.
  logic [9:0] period_ns;
  logic [5:0] calib_spans;

  tdc_tof_out_t flight_q[$];
  int  n_errors;
  int  cycle_count;
  bit  stall_enable;

  // The pipeline is 50 stages deep; allow a comfortable margin after draining.
  localparam int PIPE_LATENCY = 50;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam longint FT_MAX = 64'sd140737488355327;
  localparam longint FT_MIN = -64'sd140737488355328;

  tdc_time_of_flight_calc_top uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_beat(in_beat),
    .out_valid(out_valid), .out_stall(out_stall), .out_beat(out_beat),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Computes the flight time of one stop reading under the current settings.
  function automatic tdc_tof_out_t flight_time_of(tdc_tof_in_t rd);
    tdc_tof_out_t r;
    longint spans;
    longint den;
    longint fine;
    longint total;
    spans = longint'(calib_spans) - 1;
    den = longint'(rd.calib_second) - longint'(rd.calib_first);
    fine = 0;
    if (den != 0) begin
      // SystemVerilog integer division truncates toward zero, as needed.
      fine = (256 * longint'(period_ns) * spans *
              (longint'(rd.time_first) - longint'(rd.time_stop))) / den;
    end
    total = fine + 256 * longint'(period_ns) * longint'(rd.clock_count);
    r.saturated = 1'b0;
    if (total > FT_MAX) begin
      total = FT_MAX;
      r.saturated = 1'b1;
    end else if (total < FT_MIN) begin
      total = FT_MIN;
      r.saturated = 1'b1;
    end
    r.channel_out = rd.channel;
    r.flight_time = total[47:0];
    r.calib_equal = (den == 0);
    return r;
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int gap_len();
    if ($urandom_range(0, 3) == 0) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
    return $urandom_range(0, 3);
  endfunction

  // Cycle counter and timeout.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_top failed");
      $finish;
    end
  end

  // Random back-pressure on the result side, changed at the falling edge.
  initial begin
    int g;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_enable && $urandom_range(0, 3) == 0) begin
        g = gap_len();
        out_stall <= 1'b1;
        repeat (g + 1) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Result checker: sampled at the rising edge.
  always @(posedge clk) begin
    tdc_tof_out_t exp_r;
    if (rst_n && out_valid && !out_stall) begin
      if (flight_q.size() == 0) begin
        $error("unexpected result beat");
        n_errors++;
      end else begin
        exp_r = flight_q.pop_front();
        if (out_beat.channel_out !== exp_r.channel_out) begin
          $error("channel_out expected %0d got %0d", exp_r.channel_out,
                 out_beat.channel_out);
          n_errors++;
        end
        if (out_beat.flight_time !== exp_r.flight_time) begin
          $error("flight_time expected %0d got %0d", exp_r.flight_time,
                 out_beat.flight_time);
          n_errors++;
        end
        if (out_beat.calib_equal !== exp_r.calib_equal) begin
          $error("calib_equal expected %0d got %0d", exp_r.calib_equal,
                 out_beat.calib_equal);
          n_errors++;
        end
        if (out_beat.saturated !== exp_r.saturated) begin
          $error("saturated expected %0d got %0d", exp_r.saturated,
                 out_beat.saturated);
          n_errors++;
        end
      end
    end
  end

  // Sends one stop reading and queues its flight time once it is accepted.
  // Valid stays high between back-to-back beats; it is lowered only for gaps.
  task automatic send_reading(tdc_tof_in_t rd, bit with_gap);
    int g;
    g = with_gap ? gap_len() : 0;
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_beat  <= rd;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    flight_q.push_back(flight_time_of(rd));
    @(negedge clk);
  endtask

  // Lowers valid and waits for every expected result, then for the pipeline.
  task automatic drain();
    in_valid <= 1'b0;
    while (flight_q.size() != 0) @(negedge clk);
    repeat (PIPE_LATENCY + 5) @(negedge clk);
  endtask

  // Writes one register; only called while the block is idle. Valid drops
  // for one cycle after each write.
  task automatic write_reg(tdc_tof_reg_t idx, logic [9:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == REG_CLOCK_PERIOD) period_ns = val;
    else calib_spans = val[5:0];
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  function automatic tdc_tof_in_t make_reading(logic [22:0] c1, logic [22:0] c2,
                                               logic [22:0] tf, logic [22:0] ts,
                                               logic [22:0] cc, logic ch);
    tdc_tof_in_t rd;
    rd.channel = ch;
    rd.calib_first = c1;
    rd.calib_second = c2;
    rd.time_first = tf;
    rd.time_stop = ts;
    rd.clock_count = cc;
    return rd;
  endfunction

  // A realistic reading: calibration ratio near the span count, fine counts up
  // to twice the first calibration count, with occasional fully random fields.
  function automatic tdc_tof_in_t random_reading();
    tdc_tof_in_t rd;
    logic [22:0] c1;
    rd = tdc_tof_in_t'({$urandom, $urandom, $urandom, $urandom, $urandom});
    if ($urandom_range(0, 4) != 0) begin
      c1 = $urandom_range(1, 5000);
      rd.calib_first = c1;
      rd.calib_second = c1 * calib_spans + $urandom_range(0, 50);
      rd.time_first = $urandom_range(0, 2 * c1);
      rd.time_stop = $urandom_range(0, 2 * c1);
      rd.clock_count = $urandom_range(0, 2000);
    end
    if ($urandom_range(0, 15) == 0) rd.calib_second = rd.calib_first;
    return rd;
  endfunction

  // Field extremes and the named special cases under the reset settings.
  task automatic test_directed();
    send_reading(make_reading(0, 0, 0, 0, 0, 0), 0);
    send_reading(make_reading('1, '1, '1, '1, '1, 1), 0);
    send_reading(make_reading(0, '1, '1, 0, '1, 0), 0);
    send_reading(make_reading('1, 0, '1, 0, '1, 1), 0);
    send_reading(make_reading(0, 1, '1, 0, 0, 0), 0);
    send_reading(make_reading(1, 0, '1, 0, 0, 1), 0);
    send_reading(make_reading(0, 1, 0, '1, 0, 0), 0);
    send_reading(make_reading(1000, 10000, 700, 300, 42, 1), 0);
    send_reading(make_reading(1000, 10000, 300, 700, 42, 0), 0);
    send_reading(make_reading(5, 5, 123, 4, 99, 1), 0);
    send_reading(make_reading(23'h2AAAAA, 23'h555555, 23'h2AAAAA, 23'h555555,
                              23'h2AAAAA, 0), 0);
    send_reading(make_reading(23'h555555, 23'h2AAAAA, 23'h555555, 23'h2AAAAA,
                              23'h555555, 1), 0);
    drain();
  endtask

  // Extreme register settings, including a zero period and spans below two.
  task automatic test_extreme_settings();
    logic [9:0] periods [4] = '{10'd0, 10'd1, 10'd1023, 10'd1023};
    logic [5:0] spans   [4] = '{6'd0, 6'd1, 6'd63, 6'd2};
    for (int k = 0; k < 4; k++) begin
      write_reg(REG_CLOCK_PERIOD, periods[k]);
      write_reg(REG_CALIB_PERIODS, {4'd0, spans[k]});
      send_reading(make_reading(0, 1, '1, 0, '1, 0), 0);
      send_reading(make_reading(1, 0, '1, 0, '1, 1), 0);
      send_reading(make_reading(0, 1, 0, '1, 0, 0), 0);
      send_reading(make_reading(7, 7, 3, 9, '1, 1), 0);
      drain();
    end
  endtask

  // Random readings over several settings, with gaps and back-pressure.
  task automatic test_random_traffic();
    for (int phase = 0; phase < 8; phase++) begin
      if (phase == 0) begin
        write_reg(REG_CLOCK_PERIOD, 10'd125);
        write_reg(REG_CALIB_PERIODS, 10'd10);
      end else begin
        write_reg(REG_CLOCK_PERIOD, $urandom_range(0, 1023));
        write_reg(REG_CALIB_PERIODS, $urandom_range(0, 63));
      end
      stall_enable = (phase != 3);
      for (int n = 0; n < 200; n++) begin
        send_reading(random_reading(), (phase != 5));
        // Once, in the third phase, hold off until every queued result is back.
        if (n == 100 && phase == 2) begin
          in_valid <= 1'b0;
          while (flight_q.size() != 0) @(negedge clk);
        end
      end
      drain();
    end
  endtask

  initial begin
    n_errors = 0;
    cycle_count = 0;
    stall_enable = 1'b1;
    period_ns = PERIOD_RESET;
    calib_spans = SPANS_RESET;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_beat = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_CLOCK_PERIOD;
    cfg_data = '0;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_directed();
    test_extreme_settings();
    test_random_traffic();

    if (n_errors == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
